// ===== hw/rtl/rpp_pkg.sv =====
package rpp_pkg;

  localparam int CW     = 32;
  localparam int FB     = 16;
  localparam int PW     = 2 * CW;
  localparam int DOTW   = PW + 2;
  localparam int NUMW   = DOTW + 1;
  localparam int NMAGW  = NUMW - 1;
  localparam int DMAGW  = DOTW - 1;
  localparam int NCHUNK = 3;
  localparam int CHUNK  = NMAGW / NCHUNK;
  localparam int PPW    = CW + CHUNK;
  localparam int DW     = CW + NMAGW;
  localparam int QB     = CW + 2;
  localparam int QW     = QB + 1;
  localparam int SW     = QW + 2;
  localparam int CMPW   = DMAGW + QB;
  localparam int DIV_LAT = QB + 2;
  localparam int IDXW   = 3;
  localparam int QDEPTH = 4;
  localparam int QPTRW  = 2;

  localparam logic [CW-1:0] SMAX     = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SMIN     = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] NZ_RESET = CW'(1) << FB;

  typedef enum logic [IDXW-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic [2:0][CW-1:0] n;
  } plane_t;

  typedef struct packed {
    logic               mode;
    logic               hit;
    logic [2:0][CW-1:0] o;
    logic [2:0][CW-1:0] m;
    logic [NUMW-1:0]    num;
    logic [DOTW-1:0]    den;
  } mid_t;

endpackage

// ===== hw/rtl/rpp_queue.sv =====
module rpp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  rpp_pkg::mid_t data_i,
  input  logic          pop_i,
  output logic          empty_o,
  output rpp_pkg::mid_t data_o
);
  import rpp_pkg::*;

  mid_t             mem_q [QDEPTH];
  logic [QPTRW-1:0] wr_q, rd_q;
  logic [QPTRW:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == (QPTRW+1)'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPTRW+1)'(do_push) - (QPTRW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== hw/rtl/rpp_front.sv =====
module rpp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rpp_pkg::plane_t             plane_i,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        point_mode_i,
  input  logic [2:0][rpp_pkg::CW-1:0] origin_i,
  input  logic [2:0][rpp_pkg::CW-1:0] dir_i,
  output logic                        mid_valid_o,
  input  logic                        mid_full_i,
  output rpp_pkg::mid_t               mid_o
);
  import rpp_pkg::*;

  logic                   en;
  logic                   f1_v_q, f2_v_q, f3_v_q;
  logic                   mode1_q, mode2_q;
  logic [2:0][CW-1:0]     o1_q, m1_q, o2_q, m2_q, m_sel;
  logic signed [PW-1:0]   pd1_q [3];
  logic signed [PW-1:0]   po1_q [3];
  logic signed [PW-1:0]   pc1_q [3];
  logic signed [DOTW-1:0] den2_q, on2_q, cn2_q;
  logic signed [NUMW-1:0] num_d;
  logic                   hit_d;
  mid_t                   f3_q;

  assign en          = !(f3_v_q && mid_full_i);
  assign full_o      = !en;
  assign mid_valid_o = f3_v_q;
  assign mid_o       = f3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_sel[i] = point_mode_i ? plane_i.n[i] : dir_i[i];
    end
  end

  assign num_d = mode2_q ? (NUMW'(on2_q) - NUMW'(cn2_q)) : (NUMW'(cn2_q) - NUMW'(on2_q));
  assign hit_d = (den2_q != '0) &&
                 (mode2_q || num_d == '0 || num_d[NUMW-1] == den2_q[DOTW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= push_i;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode1_q <= point_mode_i;
      o1_q    <= origin_i;
      m1_q    <= m_sel;
      for (int i = 0; i < 3; i++) begin
        pd1_q[i] <= $signed(plane_i.n[i]) * $signed(m_sel[i]);
        po1_q[i] <= $signed(origin_i[i]) * $signed(plane_i.n[i]);
        pc1_q[i] <= $signed(plane_i.c[i]) * $signed(plane_i.n[i]);
      end
      mode2_q <= mode1_q;
      o2_q    <= o1_q;
      m2_q    <= m1_q;
      den2_q  <= DOTW'(pd1_q[0]) + DOTW'(pd1_q[1]) + DOTW'(pd1_q[2]);
      on2_q   <= DOTW'(po1_q[0]) + DOTW'(po1_q[1]) + DOTW'(po1_q[2]);
      cn2_q   <= DOTW'(pc1_q[0]) + DOTW'(pc1_q[1]) + DOTW'(pc1_q[2]);
      f3_q.mode <= mode2_q;
      f3_q.hit  <= hit_d;
      f3_q.o    <= o2_q;
      f3_q.m    <= m2_q;
      f3_q.num  <= num_d;
      f3_q.den  <= den2_q;
    end
  end

endmodule

// ===== hw/rtl/rpp_divider.sv =====
module rpp_divider (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [rpp_pkg::DW-1:0]    a_i,
  input  logic [rpp_pkg::DMAGW-1:0] b_i,
  output logic [rpp_pkg::QW-1:0]    q_o,
  output logic                      ovf_o
);
  import rpp_pkg::*;

  logic [DW-1:0]    r_q   [QB+1];
  logic [DMAGW-1:0] b_q   [QB+1];
  logic [QB-1:0]    qa_q  [QB+1];
  logic             ovf_q [QB+1];
  logic [QW-1:0]    q_q;
  logic             ovfo_q;
  logic             rnd;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= a_i;
      b_q[0]   <= b_i;
      qa_q[0]  <= '0;
      ovf_q[0] <= {1'b0, a_i} >= {b_i, {QB{1'b0}}};
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_stage
    localparam int J = QB - s;
    logic [CMPW-1:0] bsh, rx;
    logic            ge;

    assign bsh = CMPW'(b_q[s-1]) << J;
    assign rx  = CMPW'(r_q[s-1]);
    assign ge  = rx >= bsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]   <= ge ? DW'(rx - bsh) : r_q[s-1];
        b_q[s]   <= b_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        qa_q[s]  <= qa_q[s-1] | (ge ? (QB'(1) << J) : '0);
      end
    end
  end

  assign rnd = {r_q[QB], 1'b0} >= CMPW'(b_q[QB]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q    <= QW'(qa_q[QB]) + QW'(rnd);
      ovfo_q <= ovf_q[QB];
    end
  end

  assign q_o   = q_q;
  assign ovf_o = ovfo_q;

endmodule

// ===== hw/rtl/rpp_back.sv =====
module rpp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rpp_pkg::mid_t               mid_i,
  input  logic                        mid_empty_i,
  output logic                        mid_pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic                        hit_valid_o,
  output logic [2:0][rpp_pkg::CW-1:0] hit_o,
  output logic [rpp_pkg::CW-1:0]      ray_offset_o
);
  import rpp_pkg::*;

  typedef struct packed {
    logic               mode;
    logic               hit;
    logic [2:0][CW-1:0] o;
    logic [2:0]         qs;
    logic               osgn;
  } side_t;

  function automatic logic [CW-1:0] sat_sum(input logic [CW-1:0] base,
                                            input logic [QW-1:0] mag,
                                            input logic neg, input logic ovf);
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] s;
    logic [CW-1:0]        r;
    t = $signed({{(SW-QW){1'b0}}, mag});
    if (neg) t = -t;
    s = $signed({{(SW-CW){base[CW-1]}}, base}) + t;
    if (ovf) r = neg ? SMIN : SMAX;
    else if (s[SW-1:CW-1] != {(SW-CW+1){s[SW-1]}}) r = s[SW-1] ? SMIN : SMAX;
    else r = s[CW-1:0];
    return r;
  endfunction

  logic                en;
  logic [NUMW-1:0]     num_abs;
  logic [DOTW-1:0]     den_abs;
  logic [2:0][CW-1:0]  m_abs;
  side_t               s0_d;

  logic                b1_v_q, b2_v_q, b3_v_q;
  side_t               s1_q, s2_q, s3_q;
  logic [CW-1:0]       mmag1_q [3];
  logic [NMAGW-1:0]    nummag1_q, nummag2_q;
  logic [DMAGW-1:0]    denmag1_q, denmag2_q, denmag3_q;
  logic [PPW-1:0]      pp2_q [3][NCHUNK];
  logic [DW-1:0]       diva3_q [4];

  logic [QW-1:0]       q_l [4];
  logic                ovf_l [4];

  side_t               sp_q [DIV_LAT];
  logic                sv_q [DIV_LAT];
  side_t               sd;

  logic [2:0][CW-1:0]  h_d;
  logic [CW-1:0]       off_d;

  logic                out_v_q, out_hit_q, out_mode_q;
  logic [2:0][CW-1:0]  hit_q;
  logic [CW-1:0]       off_q;

  assign en        = !out_v_q || pop_i;
  assign mid_pop_o = en;

  assign num_abs = mid_i.num[NUMW-1] ? (~mid_i.num + 1'b1) : mid_i.num;
  assign den_abs = mid_i.den[DOTW-1] ? (~mid_i.den + 1'b1) : mid_i.den;

  always_comb begin
    s0_d.mode = mid_i.mode;
    s0_d.hit  = mid_i.hit;
    s0_d.o    = mid_i.o;
    s0_d.osgn = mid_i.num[NUMW-1] ^ mid_i.den[DOTW-1];
    for (int i = 0; i < 3; i++) begin
      m_abs[i]   = mid_i.m[i][CW-1] ? (~mid_i.m[i] + 1'b1) : mid_i.m[i];
      s0_d.qs[i] = mid_i.m[i][CW-1] ^ s0_d.osgn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      b3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) sv_q[k] <= 1'b0;
    end else if (en) begin
      b1_v_q  <= !mid_empty_i;
      b2_v_q  <= b1_v_q;
      b3_v_q  <= b2_v_q;
      sv_q[0] <= b3_v_q;
      for (int k = 1; k < DIV_LAT; k++) sv_q[k] <= sv_q[k-1];
      out_v_q <= sv_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q      <= s0_d;
      nummag1_q <= num_abs[NMAGW-1:0];
      denmag1_q <= den_abs[DMAGW-1:0];
      for (int i = 0; i < 3; i++) mmag1_q[i] <= m_abs[i];

      s2_q      <= s1_q;
      nummag2_q <= nummag1_q;
      denmag2_q <= denmag1_q;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < NCHUNK; k++) begin
          pp2_q[i][k] <= PPW'(mmag1_q[i]) * PPW'(nummag1_q[k*CHUNK +: CHUNK]);
        end
      end

      s3_q      <= s2_q;
      denmag3_q <= denmag2_q;
      for (int i = 0; i < 3; i++) begin
        diva3_q[i] <= DW'(pp2_q[i][0]) + (DW'(pp2_q[i][1]) << CHUNK) +
                      (DW'(pp2_q[i][2]) << (2 * CHUNK));
      end
      diva3_q[3] <= DW'(nummag2_q) << FB;

      sp_q[0] <= s3_q;
      for (int k = 1; k < DIV_LAT; k++) sp_q[k] <= sp_q[k-1];
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_div
    rpp_divider u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (diva3_q[l]),
      .b_i   (denmag3_q),
      .q_o   (q_l[l]),
      .ovf_o (ovf_l[l])
    );
  end

  assign sd = sp_q[DIV_LAT-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_d[i] = sat_sum(sd.o[i], q_l[i], sd.qs[i] ^ sd.mode, ovf_l[i]);
    end
    off_d = sat_sum('0, q_l[3], !sd.osgn, ovf_l[3]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q  <= sd.hit;
      out_mode_q <= sd.mode;
      hit_q      <= sd.hit ? h_d : '0;
      off_q      <= (sd.hit && !sd.mode) ? off_d : '0;
    end
  end

  assign empty_o      = !out_v_q;
  assign hit_valid_o  = out_hit_q;
  assign hit_o        = hit_q;
  assign ray_offset_o = off_q;

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_hit_q |-> hit_q == '0 && off_q == '0)
    else $error("miss word carries nonzero fields");

  a_point_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_mode_q |-> off_q == '0)
    else $error("point word carries a ray offset");

  a_ray_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_hit_q && !out_mode_q |-> off_q[CW-1] || off_q == '0)
    else $error("ray offset positive on a hit");

endmodule

// ===== hw/rtl/ray_plane_projector_top.sv =====
// Ray / plane projector.
// Input channel (push, full): one word per ray or point; taken on a rising
// edge with push high and full low. point_mode selects orthogonal projection
// of the origin onto the plane, otherwise ray intersection along dir.
// Result channel (empty, pop): the oldest result sits on the hit ports while
// empty is low and leaves on an edge with pop high and empty low.
// Config channel (cfg_valid_i, cfg_ready_o): ready is always high; index
// picks centre x/y/z (0..2) or normal x/y/z (3..5); other indexes are dropped.
// Write it only while no word is in flight.
// Throughput: one word per cycle while results are popped, set by the fully
// pipelined front multipliers and four 34-stage restoring back-end dividers.
// Path from the accepting edge to the result, without stalls: three front
// stages, the queue, three back stages, 36 divider stages and the output
// register.
// When pop is held low while a result waits, the back end freezes; the
// four-entry queue between front and back then fills, after which full rises.
// Reset clears all valid state, sets the centre to 0 and the normal to
// (0, 0, 1.0).
module ray_plane_projector_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [rpp_pkg::IDXW-1:0]   cfg_index_i,
  input  logic [rpp_pkg::CW-1:0]     cfg_data_i,
  input  logic                       push,
  output logic                       full,
  input  logic                       point_mode_i,
  input  logic [rpp_pkg::CW-1:0]     origin_x_i,
  input  logic [rpp_pkg::CW-1:0]     origin_y_i,
  input  logic [rpp_pkg::CW-1:0]     origin_z_i,
  input  logic [rpp_pkg::CW-1:0]     dir_x_i,
  input  logic [rpp_pkg::CW-1:0]     dir_y_i,
  input  logic [rpp_pkg::CW-1:0]     dir_z_i,
  output logic                       empty,
  input  logic                       pop,
  output logic                       hit_valid_o,
  output logic [rpp_pkg::CW-1:0]     hit_x_o,
  output logic [rpp_pkg::CW-1:0]     hit_y_o,
  output logic [rpp_pkg::CW-1:0]     hit_z_o,
  output logic [rpp_pkg::CW-1:0]     ray_offset_o
);
  import rpp_pkg::*;

  plane_t             plane_q;
  mid_t               fq_data, qb_data;
  logic               fq_valid, fq_full, qb_empty, qb_pop;
  logic [2:0][CW-1:0] hit_w;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q.c    <= '0;
      plane_q.n[0] <= '0;
      plane_q.n[1] <= '0;
      plane_q.n[2] <= NZ_RESET;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_CENTER_X: plane_q.c[0] <= cfg_data_i;
        REG_CENTER_Y: plane_q.c[1] <= cfg_data_i;
        REG_CENTER_Z: plane_q.c[2] <= cfg_data_i;
        REG_NORMAL_X: plane_q.n[0] <= cfg_data_i;
        REG_NORMAL_Y: plane_q.n[1] <= cfg_data_i;
        REG_NORMAL_Z: plane_q.n[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rpp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plane_i      (plane_q),
    .push_i       (push),
    .full_o       (full),
    .point_mode_i (point_mode_i),
    .origin_i     ({origin_z_i, origin_y_i, origin_x_i}),
    .dir_i        ({dir_z_i, dir_y_i, dir_x_i}),
    .mid_valid_o  (fq_valid),
    .mid_full_i   (fq_full),
    .mid_o        (fq_data)
  );

  rpp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_valid),
    .full_o  (fq_full),
    .data_i  (fq_data),
    .pop_i   (qb_pop),
    .empty_o (qb_empty),
    .data_o  (qb_data)
  );

  rpp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mid_i        (qb_data),
    .mid_empty_i  (qb_empty),
    .mid_pop_o    (qb_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .hit_valid_o  (hit_valid_o),
    .hit_o        (hit_w),
    .ray_offset_o (ray_offset_o)
  );

  assign hit_x_o = hit_w[0];
  assign hit_y_o = hit_w[1];
  assign hit_z_o = hit_w[2];

endmodule
